[rtl/core/sacache_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory package
// Shared types and constants of the set-associative cache directory.
// ----------------------------------------------------------------------------
package sacache_pkg;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned AGE_W    = 8;
   localparam int unsigned USE_W    = 16;
   localparam int unsigned POLICY_W = 2;
   localparam int unsigned WAYS_W   = 3;
   localparam int unsigned SBITS_W  = 3;
   localparam int unsigned SET_OUT_W = 6;
   localparam int unsigned WAY_OUT_W = 2;
   localparam int unsigned MAX_WAYS_REG = 4;
   localparam int unsigned MAX_SBITS_REG = 6;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [POLICY_W-1:0] {
      POL_FIFO = 2'd0,
      POL_LRU  = 2'd1,
      POL_LFU  = 2'd2,
      POL_ALT  = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY = 2'd0,
      CSR_WAYS   = 2'd1,
      CSR_SBITS  = 2'd2,
      CSR_NONE   = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_HOLD
   } state_type;

endpackage

[rtl/core/sacache_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface sacache_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] block_address;
   modport source (output valid, output block_address, input ready);
   modport sink   (input valid, input block_address, output ready);
endinterface

interface sacache_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [1:0]  way;
   logic [5:0]  set_index;
   logic        filled_empty;
   logic        evicted;
   logic [15:0] evicted_block;
   modport source (output valid, output hit, output way, output set_index,
                   output filled_empty, output evicted, output evicted_block,
                   input ready);
   modport sink   (input valid, input hit, input way, input set_index,
                   input filled_empty, input evicted, input evicted_block,
                   output ready);
endinterface

interface sacache_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/sacache_victim.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory way selection
// Hit search, empty search and victim choice over the ways of one set.
// ----------------------------------------------------------------------------
module sacache_victim #(
   parameter int unsigned NUM_WAYS = 4
) (
   input  logic [NUM_WAYS-1:0]                          valid_i,
   input  logic [NUM_WAYS-1:0][sacache_pkg::ADDR_W-1:0] tag_i,
   input  logic [NUM_WAYS-1:0][sacache_pkg::AGE_W-1:0]  age_i,
   input  logic [NUM_WAYS-1:0][sacache_pkg::USE_W-1:0]  use_i,
   input  logic [sacache_pkg::ADDR_W-1:0]               addr_i,
   input  logic [sacache_pkg::WAYS_W-1:0]               ways_i,
   input  sacache_pkg::policy_type                      policy_i,
   input  logic [sacache_pkg::WAY_OUT_W-1:0]            fifo_i,
   output logic                                         hit_o,
   output logic                                         empty_o,
   output logic [sacache_pkg::WAY_OUT_W-1:0]            pick_o
);

   logic [sacache_pkg::WAY_OUT_W-1:0] hit_way;
   logic [sacache_pkg::WAY_OUT_W-1:0] empty_way;
   logic [sacache_pkg::WAY_OUT_W-1:0] lru_way;
   logic [sacache_pkg::WAY_OUT_W-1:0] lfu_way;
   logic [sacache_pkg::AGE_W-1:0]     best_age;
   logic [sacache_pkg::USE_W-1:0]     best_use;
   logic [sacache_pkg::WAY_OUT_W-1:0] fifo_way;

   always_comb begin
      hit_o = 1'b0;
      hit_way = '0;
      empty_o = 1'b0;
      empty_way = '0;
      best_age = age_i[0];
      best_use = use_i[0];
      lru_way = '0;
      lfu_way = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (i < 32'(ways_i)) begin
            if (valid_i[i] && tag_i[i] == addr_i) begin
               hit_o = 1'b1;
               hit_way = sacache_pkg::WAY_OUT_W'(i);
            end
            if (!valid_i[i]) begin
               empty_o = 1'b1;
               empty_way = sacache_pkg::WAY_OUT_W'(i);
            end
         end
      end
      for (int i = 1; i < NUM_WAYS; i++) begin
         if (i < 32'(ways_i)) begin
            if (age_i[i] > best_age) begin
               best_age = age_i[i];
               lru_way = sacache_pkg::WAY_OUT_W'(i);
            end
            if (use_i[i] < best_use) begin
               best_use = use_i[i];
               lfu_way = sacache_pkg::WAY_OUT_W'(i);
            end
         end
      end
      fifo_way = (32'(fifo_i) >= 32'(ways_i)) ? '0 : fifo_i;
      if (hit_o) begin
         pick_o = hit_way;
      end else if (empty_o) begin
         pick_o = empty_way;
      end else begin
         case (policy_i)
            sacache_pkg::POL_FIFO: pick_o = fifo_way;
            sacache_pkg::POL_LFU:  pick_o = lfu_way;
            default:               pick_o = lru_way;
         endcase
      end
   end

endmodule

[rtl/core/set_assoc_cache_lookup_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache directory
// Looks each request address up in its set, reports hit or the line filled,
// and keeps FIFO pointers, ages and use counts for replacement.
//
// Requests arrive on req_ with one block address each; every request gives
// exactly one response on rsp_. Registers policy, active_ways and set_bits
// are written on csr_; the user is to do so only while the block is idle,
// which the block does not enforce. A request first reads its set row from
// the directory memory into a register, then chooses the way and writes the
// row back. The next request is taken while the response waits on rsp_, but
// not before the row of the last one is written back.
// Reset clears valid bits, ages, use counts and FIFO pointers by a clearing
// pass of all NUM_SETS sets, one set per cycle; no request is taken meanwhile.
// When rsp_ stalls, the held response stays put and at most one more request
// is read and waits until the response register frees up.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_replace #(
   parameter int unsigned NUM_SETS = 64,
   parameter int unsigned NUM_WAYS = 4
) (
   input logic           clock,
   input logic           reset,
   sacache_req_if.sink   req_if,
   sacache_rsp_if.source rsp_if,
   sacache_csr_if.sink   csr_if
);

   localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned CLR_W = $clog2(NUM_SETS + 1);
   localparam int unsigned ADDR_W = sacache_pkg::ADDR_W;
   localparam int unsigned AGE_W = sacache_pkg::AGE_W;
   localparam int unsigned USE_W = sacache_pkg::USE_W;
   localparam int unsigned WO_W = sacache_pkg::WAY_OUT_W;

   typedef struct packed {
      logic [NUM_WAYS-1:0]             valid;
      logic [NUM_WAYS-1:0][ADDR_W-1:0] tag;
      logic [NUM_WAYS-1:0][AGE_W-1:0]  age;
      logic [NUM_WAYS-1:0][USE_W-1:0]  cnt;
      logic [WO_W-1:0]                 fifo;
   } row_type;

   row_type mem [NUM_SETS];
   row_type rd_row_ff;
   row_type wr_row;
   row_type cur_row;

   sacache_pkg::state_type state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   sacache_pkg::policy_type policy_ff;
   logic [sacache_pkg::WAYS_W-1:0]  ways_reg_ff;
   logic [sacache_pkg::SBITS_W-1:0] sbits_reg_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SET_W-1:0]  set_ff;

   logic [sacache_pkg::WAYS_W-1:0]  ways_eff;
   logic [sacache_pkg::SBITS_W-1:0] sb_eff;
   logic [SET_W-1:0] req_set;
   logic [SET_W-1:0] rd_addr;
   logic [SET_W-1:0] wr_addr;
   logic             wr_en;
   logic             rd_en;
   logic             fwd_ff;
   logic             req_take;
   logic             out_free;

   logic v_hit, v_empty;
   logic [WO_W-1:0] v_pick;

   logic        rsp_valid_ff;
   logic        rsp_hit_ff, rsp_fill_ff, rsp_evict_ff;
   logic [1:0]  rsp_way_ff;
   logic [5:0]  rsp_set_ff;
   logic [15:0] rsp_old_ff;

   always_comb begin
      ways_eff = sacache_pkg::WAYS_W'(sacache_pkg::MAX_WAYS_REG);
      if (ways_reg_ff == '0) begin
         ways_eff = 3'd1;
      end else if (ways_reg_ff < ways_eff) begin
         ways_eff = ways_reg_ff;
      end
      if (32'(ways_eff) > NUM_WAYS) begin
         ways_eff = sacache_pkg::WAYS_W'(NUM_WAYS);
      end
      sb_eff = (sbits_reg_ff > 3'(sacache_pkg::MAX_SBITS_REG))
               ? 3'(sacache_pkg::MAX_SBITS_REG) : sbits_reg_ff;
      for (int k = 0; k < 7; k++) begin
         if (sb_eff != '0 && (32'd1 << sb_eff) > NUM_SETS) begin
            sb_eff = sb_eff - 3'd1;
         end
      end
      req_set = SET_W'(req_if.block_address & ((16'd1 << sb_eff) - 16'd1));
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == sacache_pkg::ST_IDLE);
   assign req_take = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         sacache_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = sacache_pkg::ST_READ;
            end
         end
         sacache_pkg::ST_READ: begin
            if (out_free) begin
               state_in = sacache_pkg::ST_IDLE;
            end
         end
         sacache_pkg::ST_HOLD: begin
            clr_in = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == NUM_SETS - 1) begin
               state_in = sacache_pkg::ST_IDLE;
            end
         end
         default: state_in = sacache_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacache_pkg::ST_HOLD;
         clr_ff <= '0;
         policy_ff <= sacache_pkg::POL_LRU;
         ways_reg_ff <= 3'd4;
         sbits_reg_ff <= 3'd4;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_if.valid) begin
            case (sacache_pkg::csr_idx_type'(csr_if.index))
               sacache_pkg::CSR_POLICY:
                  policy_ff <= sacache_pkg::policy_type'(csr_if.data[1:0]);
               sacache_pkg::CSR_WAYS:  ways_reg_ff <= csr_if.data[2:0];
               sacache_pkg::CSR_SBITS: sbits_reg_ff <= csr_if.data[2:0];
               default: ;
            endcase
         end
      end
   end

   // Row read; a request to the set being written sees the written row.
   assign rd_en = req_take;
   assign rd_addr = req_set;
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
         addr_ff <= req_if.block_address;
         set_ff <= req_set;
      end
      fwd_ff <= rd_en && wr_en && (rd_addr == wr_addr);
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   row_type last_wr_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_ff <= wr_row;
      end
   end
   assign cur_row = fwd_ff ? last_wr_ff : rd_row_ff;

   sacache_victim #(.NUM_WAYS(NUM_WAYS)) u_victim (
      .valid_i  (cur_row.valid),
      .tag_i    (cur_row.tag),
      .age_i    (cur_row.age),
      .use_i    (cur_row.cnt),
      .addr_i   (addr_ff),
      .ways_i   (ways_eff),
      .policy_i (policy_ff),
      .fifo_i   (cur_row.fifo),
      .hit_o    (v_hit),
      .empty_o  (v_empty),
      .pick_o   (v_pick)
   );

   logic fire;
   logic [WO_W-1:0] fifo_p;
   assign fire = (state_ff == sacache_pkg::ST_READ) && out_free;

   always_comb begin
      wr_row = cur_row;
      wr_addr = set_ff;
      wr_en = fire;
      fifo_p = (32'(cur_row.fifo) >= 32'(ways_eff)) ? '0 : cur_row.fifo;
      if (!v_hit) begin
         wr_row.tag[v_pick] = addr_ff;
         wr_row.valid[v_pick] = 1'b1;
         if (!v_empty && policy_ff == sacache_pkg::POL_FIFO) begin
            wr_row.fifo = (32'(fifo_p) + 1 >= 32'(ways_eff)) ? '0 : fifo_p + WO_W'(1);
         end
      end
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (i < 32'(ways_eff) && cur_row.age[i] != '1) begin
            wr_row.age[i] = cur_row.age[i] + AGE_W'(1);
         end
      end
      wr_row.age[v_pick] = '0;
      if (!v_hit) begin
         wr_row.cnt[v_pick] = USE_W'(1);
      end else if (cur_row.cnt[v_pick] != '1) begin
         wr_row.cnt[v_pick] = cur_row.cnt[v_pick] + USE_W'(1);
      end
      if (state_ff == sacache_pkg::ST_HOLD) begin
         wr_en = 1'b1;
         wr_addr = SET_W'(clr_ff);
         wr_row = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_hit_ff <= v_hit;
         rsp_way_ff <= 2'(v_pick);
         rsp_set_ff <= 6'(set_ff);
         rsp_fill_ff <= !v_hit && v_empty;
         rsp_evict_ff <= !v_hit && !v_empty;
         rsp_old_ff <= (!v_hit && !v_empty) ? cur_row.tag[v_pick] : '0;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.hit = rsp_hit_ff;
   assign rsp_if.way = rsp_way_ff;
   assign rsp_if.set_index = rsp_set_ff;
   assign rsp_if.filled_empty = rsp_fill_ff;
   assign rsp_if.evicted = rsp_evict_ff;
   assign rsp_if.evicted_block = rsp_old_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == sacache_pkg::ST_HOLD |-> !req_take)
      else $error("request accepted during clearing pass");
   a_fire_sets_valid: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("response lost");
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && (rsp_fill_ff || rsp_evict_ff)))
      else $error("hit flagged with fill or eviction");

endmodule

[tb/sv/set_assoc_cache_lookup_replace_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory testbench
// Drives block addresses under several register settings and idle patterns,
// predicts hit, way, set and eviction for each request with a local model of
// the directory, and compares every response field against it in order.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_replace_test;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic [5:0]  set_index;
      logic        filled_empty;
      logic        evicted;
      logic [15:0] evicted_block;
   } lookup_result_type;

   logic clock;
   logic reset;

   sacache_req_if req_ch ();
   sacache_rsp_if rsp_ch ();
   sacache_csr_if csr_ch ();

   set_assoc_cache_lookup_replace DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source),
      .csr_if (csr_ch.sink)
   );

   logic [15:0] tags [256];
   logic        line_valid [256];
   logic [1:0]  rr_ptr [64];
   logic [7:0]  line_age [256];
   logic [15:0] line_uses [256];
   sacache_pkg::policy_type cur_policy;
   logic [2:0]  cur_ways;
   logic [2:0]  cur_sbits;

   logic [15:0]       pending_addrs [$];
   lookup_result_type expected_results [$];
   int  failures;
   int  send_idle_pct;
   int  stall_pct;
   int  hold_cycles;

   function automatic lookup_result_type predict_lookup(input logic [15:0] addr);
      lookup_result_type r;
      int ways;
      int sb;
      int set;
      int base;
      int pick;
      int best;
      bit found;
      bit empty;
      ways = (cur_ways == 0) ? 1 : ((cur_ways > 4) ? 4 : cur_ways);
      sb = (cur_sbits > 6) ? 6 : cur_sbits;
      set = addr & ((1 << sb) - 1);
      base = set * 4;
      pick = 0;
      found = 0;
      empty = 0;
      r = '0;
      for (int i = 0; i < ways; i++) begin
         if (!found && line_valid[base+i] && tags[base+i] == addr) begin
            pick = i;
            found = 1;
         end
      end
      if (!found) begin
         for (int i = 0; i < ways; i++) begin
            if (!empty && !line_valid[base+i]) begin
               pick = i;
               empty = 1;
            end
         end
         if (!empty) begin
            if (cur_policy == sacache_pkg::POL_FIFO) begin
               pick = (rr_ptr[set] >= ways) ? 0 : rr_ptr[set];
               rr_ptr[set] = (pick + 1 >= ways) ? 2'd0 : 2'(pick + 1);
            end else if (cur_policy == sacache_pkg::POL_LFU) begin
               best = line_uses[base];
               for (int i = 1; i < ways; i++) begin
                  if (line_uses[base+i] < best) begin
                     best = line_uses[base+i];
                     pick = i;
                  end
               end
            end else begin
               best = line_age[base];
               for (int i = 1; i < ways; i++) begin
                  if (line_age[base+i] > best) begin
                     best = line_age[base+i];
                     pick = i;
                  end
               end
            end
            r.evicted = 1;
            r.evicted_block = tags[base+pick];
         end
         tags[base+pick] = addr;
         line_valid[base+pick] = 1;
      end
      for (int i = 0; i < ways; i++) begin
         if (line_age[base+i] != 8'hFF) line_age[base+i]++;
      end
      line_age[base+pick] = 0;
      if (!found) line_uses[base+pick] = 1;
      else if (line_uses[base+pick] != 16'hFFFF) line_uses[base+pick]++;
      r.hit = found;
      r.way = 2'(pick);
      r.set_index = 6'(set);
      r.filled_empty = empty;
      return r;
   endfunction

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The driver predicts at acceptance so expectations follow request order.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_lookup(req_ch.block_address));
            void'(pending_addrs.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            req_ch.valid <= 1'b1;
         end else if (pending_addrs.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.block_address <= pending_addrs[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               lookup_result_type e;
               e = expected_results.pop_front();
               if (rsp_ch.hit !== e.hit) begin
                  $error("hit expected %0d actual %0d", e.hit, rsp_ch.hit);
                  failures++;
               end
               if (rsp_ch.way !== e.way) begin
                  $error("way expected %0d actual %0d", e.way, rsp_ch.way);
                  failures++;
               end
               if (rsp_ch.set_index !== e.set_index) begin
                  $error("set_index expected %0d actual %0d", e.set_index,
                         rsp_ch.set_index);
                  failures++;
               end
               if (rsp_ch.filled_empty !== e.filled_empty) begin
                  $error("filled_empty expected %0d actual %0d", e.filled_empty,
                         rsp_ch.filled_empty);
                  failures++;
               end
               if (rsp_ch.evicted !== e.evicted) begin
                  $error("evicted expected %0d actual %0d", e.evicted,
                         rsp_ch.evicted);
                  failures++;
               end
               if (rsp_ch.evicted_block !== e.evicted_block) begin
                  $error("evicted_block expected %h actual %h", e.evicted_block,
                         rsp_ch.evicted_block);
                  failures++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic write_reg(input sacache_pkg::csr_idx_type idx,
                            input logic [15:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         sacache_pkg::CSR_POLICY: cur_policy = sacache_pkg::policy_type'(value[1:0]);
         sacache_pkg::CSR_WAYS:   cur_ways = value[2:0];
         sacache_pkg::CSR_SBITS:  cur_sbits = value[2:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_addrs.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic add_random(input int count, input int span);
      logic [15:0] recent [$];
      logic [15:0] a;
      for (int k = 0; k < count; k++) begin
         if (recent.size() > 0 && $urandom_range(99) < 45)
            a = recent[$urandom_range(recent.size() - 1)];
         else if ($urandom_range(99) < 80)
            a = 16'($urandom_range(span - 1));
         else
            a = 16'($urandom);
         recent.push_back(a);
         if (recent.size() > 24) void'(recent.pop_front());
         pending_addrs.push_back(a);
      end
   endtask

   task automatic run_phase(input sacache_pkg::policy_type pol, input logic [2:0] ways,
                            input logic [2:0] sbits, input int count,
                            input int span, input int idle, input int stall);
      write_reg(sacache_pkg::CSR_POLICY, 16'(pol));
      write_reg(sacache_pkg::CSR_WAYS, {13'h1fff, ways});
      write_reg(sacache_pkg::CSR_SBITS, 16'(sbits));
      send_idle_pct = idle;
      stall_pct = stall;
      add_random(count, span);
      drain();
   endtask

   initial begin
      #2000000;
      $display("set_assoc_cache_lookup_replace: mismatch");
      $finish;
   end

   initial begin
      logic [15:0] directed [$];
      reset = 1'b1;
      failures = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.block_address = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = sacache_pkg::CSR_NONE;
      csr_ch.data = '0;
      cur_policy = sacache_pkg::POL_LRU;
      cur_ways = 3'd4;
      cur_sbits = 3'd4;
      for (int i = 0; i < 256; i++) begin
         tags[i] = '0;
         line_valid[i] = 0;
         line_age[i] = 0;
         line_uses[i] = 0;
      end
      for (int i = 0; i < 64; i++) rr_ptr[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, fills, hits and LRU eviction in one set.
      directed = '{16'h0000, 16'hFFFF, 16'h0010, 16'h0020, 16'h0030, 16'h0040,
                   16'h0000, 16'h0010, 16'h0050, 16'hFFFF, 16'hFFF0, 16'h5555,
                   16'hAAAA, 16'h0050};
      foreach (directed[i]) pending_addrs.push_back(directed[i]);
      drain();

      run_phase(sacache_pkg::POL_FIFO, 3'd4, 3'd2, 20, 64, 0, 0);
      run_phase(sacache_pkg::POL_LFU, 3'd4, 3'd1, 20, 32, 0, 0);
      run_phase(sacache_pkg::POL_ALT, 3'd3, 3'd1, 15, 32, 0, 0);
      run_phase(sacache_pkg::POL_LRU, 3'd0, 3'd6, 15, 256, 0, 0);
      run_phase(sacache_pkg::POL_FIFO, 3'd7, 3'd7, 15, 512, 0, 0);
      run_phase(sacache_pkg::POL_LRU, 3'd1, 3'd0, 10, 8, 0, 0);

      run_phase(sacache_pkg::POL_LRU, 3'd4, 3'd0, 160, 12, 0, 0);
      run_phase(sacache_pkg::POL_FIFO, 3'd3, 3'd2, 160, 40, 52, 0);
      run_phase(sacache_pkg::POL_LFU, 3'd4, 3'd3, 160, 64, 0, 52);
      run_phase(sacache_pkg::POL_FIFO, 3'd4, 3'd0, 150, 10, 30, 30);
      run_phase(sacache_pkg::POL_LFU, 3'd2, 3'd6, 150, 400, 52, 0);
      run_phase(sacache_pkg::POL_ALT, 3'd1, 3'd4, 120, 64, 0, 52);

      // Long receiver hold-off while requests keep coming.
      hold_cycles = 200;
      run_phase(sacache_pkg::POL_LRU, 3'd4, 3'd5, 150, 200, 0, 30);
      run_phase(sacache_pkg::POL_FIFO, 3'd2, 3'd0, 80, 6, 30, 30);

      if (failures == 0) begin
         $display("set_assoc_cache_lookup_replace: match");
      end else begin
         $display("set_assoc_cache_lookup_replace: mismatch");
      end
      $finish;
   end

endmodule
